// ===== src/srs_pkg.sv =====
// Package for the shutter release sequencer.
// Holds phase and action codes, configuration indexes and field widths.
// No dependencies.
package srs_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 15;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned ActW   = 2;

  typedef logic [0:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MODE  = 1'b0;
  localparam cfg_idx_t CFG_DELAY = 1'b1;

  localparam logic [ModeW-1:0] MODE_OFF    = 2'd0;
  localparam logic [ModeW-1:0] MODE_SINGLE = 2'd1;
  localparam logic [ModeW-1:0] MODE_BULB   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DELAY  = 3'd1,
    PH_SINGLE = 3'd2,
    PH_BULB   = 3'd3,
    PH_TIME   = 3'd4
  } phase_t;

  typedef enum logic [ActW-1:0] {
    ACT_IDLE    = 2'd0,
    ACT_PENDING = 2'd1,
    ACT_START   = 2'd2,
    ACT_STOP    = 2'd3
  } act_code_t;

endpackage

// ===== src/shutter_release_sequencer_top.sv =====
// Shutter release sequencer, top level.
// Depends on srs_pkg for phase and action codes and configuration indexes.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one button sample: in_pin_level
//   and the millisecond time in_now_ms. Each accepted item gives exactly one
//   result item on the output channel (out_valid/out_ready), out_action:
//   0 idle, 1 pending, 2 start exposure, 3 stop exposure.
//   Configuration channel (cfg_valid/cfg_ready) writes mode (index 0) or
//   delay_ms (index 1) from cfg_data; cfg_ready is always high. Write it only
//   while no item is in flight.
//   The result is registered and appears in the cycle after the item is accepted.
//   Throughput: one item per clock while out_ready is high; edge detection, elapsed-time
//   subtract and compare all sit between the input handshake and the result register.
//   A held result stalls intake only while out_ready is low; in_ready is high
//   whenever the result register is empty or being drained the same cycle.
//   Reset (rst_n low, synchronous): phase idle, stored level low, trigger
//   time zero, mode off, delay zero, no result pending.
module shutter_release_sequencer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_pin_level,
  input  logic [srs_pkg::TimeW-1:0]       in_now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [srs_pkg::ActW-1:0]        out_action,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  srs_pkg::cfg_idx_t               cfg_index,
  input  logic [srs_pkg::DelayW-1:0]      cfg_data
);
  import srs_pkg::*;

  logic [ModeW-1:0]  mode_r;
  logic [DelayW-1:0] delay_r;
  phase_t            phase_r, phase_nxt;
  logic              last_level_r, last_level_nxt;
  logic [TimeW-1:0]  trig_time_r, trig_time_nxt;
  logic              out_valid_r, out_valid_nxt;
  act_code_t         action_r, action_nxt;

  logic              in_fire;
  logic              rise, fall;
  logic [TimeW-1:0]  elapsed;
  logic              delay_done;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_action = action_r;

  assign rise       = !last_level_r && in_pin_level;
  assign fall       = last_level_r && !in_pin_level;
  assign elapsed    = in_now_ms - trig_time_r;
  assign delay_done = elapsed >= {{(TimeW-DelayW){1'b0}}, delay_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFF;
      delay_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[ModeW-1:0];
        CFG_DELAY: delay_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    last_level_nxt = last_level_r;
    trig_time_nxt  = trig_time_r;
    action_nxt     = action_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      action_nxt    = ACT_IDLE;
      if (mode_r != MODE_OFF) begin
        last_level_nxt = in_pin_level;
        unique case (phase_r)
          PH_IDLE: begin
            if (rise) begin
              trig_time_nxt = in_now_ms;
              phase_nxt     = PH_DELAY;
              action_nxt    = ACT_PENDING;
            end
          end
          PH_DELAY: begin
            if (delay_done) begin
              if (mode_r == MODE_SINGLE) begin
                phase_nxt = PH_SINGLE;
              end else if (mode_r == MODE_BULB) begin
                phase_nxt = PH_BULB;
              end else begin
                phase_nxt = PH_TIME;
              end
              action_nxt = ACT_START;
            end else begin
              action_nxt = ACT_PENDING;
            end
          end
          PH_SINGLE: begin
            phase_nxt  = PH_IDLE;
            action_nxt = ACT_STOP;
          end
          PH_BULB: begin
            if (fall) begin
              phase_nxt  = PH_IDLE;
              action_nxt = ACT_STOP;
            end else begin
              action_nxt = ACT_PENDING;
            end
          end
          PH_TIME: begin
            if (rise) begin
              phase_nxt  = PH_IDLE;
              action_nxt = ACT_STOP;
            end else begin
              action_nxt = ACT_PENDING;
            end
          end
          default: action_nxt = ACT_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      last_level_r <= 1'b0;
      trig_time_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      last_level_r <= last_level_nxt;
      trig_time_r  <= trig_time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
  end

  a_stall_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("intake open while result is stalled");

  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

  a_start_enters_exposure: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (action_r != ACT_START || phase_r == PH_SINGLE ||
                 phase_r == PH_BULB || phase_r == PH_TIME))
    else $error("start reported without entering an exposure phase");

  a_off_freezes_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode_r == MODE_OFF) |=>
      (phase_r == $past(phase_r) && last_level_r == $past(last_level_r) &&
       action_r == ACT_IDLE))
    else $error("state moved while mode is off");

endmodule
